// ----- hdl/c3rmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package c3rmt_pkg;
    localparam int unsigned DefNumFilters = 8;
    localparam int unsigned DefOutH = 14;
    localparam int unsigned DefOutW = 14;
    localparam int unsigned DefInW = 16;
    localparam int unsigned DefStride = 1;
    localparam int unsigned DefHiddenCount = 1568;
    localparam int unsigned Taps = 9;
    localparam int unsigned Ksize = 3;
    localparam int unsigned ImageDepth = 256;

    localparam logic [2:0] MODE_LOAD_W = 3'd0;
    localparam logic [2:0] MODE_LOAD_P = 3'd1;
    localparam logic [2:0] MODE_LOAD_E = 3'd2;
    localparam logic [2:0] MODE_FWD = 3'd3;
    localparam logic [2:0] MODE_BWD = 3'd4;
    localparam logic [2:0] MODE_READ_W = 3'd5;
    localparam logic [2:0] MODE_CLEAR = 3'd6;

    localparam logic REG_RATE = 1'b0;
    localparam logic REG_MOMENTUM = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic [10:0] index;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] result_value;
        logic [2:0] filter_number;
        logic last;
    } t_out_item;

    typedef struct packed {
        logic index;
        logic [15:0] data;
    } t_cfg_item;
endpackage
`default_nettype wire

// ----- hdl/c3rmt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface c3rmt_in_if;
    logic valid;
    logic ready;
    c3rmt_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface c3rmt_out_if;
    logic valid;
    logic ready;
    c3rmt_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface c3rmt_cfg_if;
    logic valid;
    logic ready;
    c3rmt_pkg::t_cfg_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/conv3x3_relu_momentum_trainer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Forward position: per filter, S_F_ADDR, S_F_MUL, S_F_ACC per tap, then S_F_OUT issues the
// result once the result register is free (o_out.ready). Backward: S_SCALE forms the scale;
// per weight, S_B_ADDR, S_B_MUL, S_B_ACC per position, and S_B_MOM, S_B_SCL, S_B_SCH, S_B_UPD;
// then S_W_RD, S_W_UPD per weight update. Products use one shared 33x33 multiplier.
// Loads and clear finish in idle, a weight read passes S_R_RD and S_R_OUT; one item at a time.
// Reset (synchronous, active low) resets control, change valid bits and rate/momentum only.
module conv3x3_relu_momentum_trainer #(
    parameter int unsigned NUM_FILTERS = c3rmt_pkg::DefNumFilters,
    parameter int unsigned OUT_H = c3rmt_pkg::DefOutH,
    parameter int unsigned OUT_W = c3rmt_pkg::DefOutW,
    parameter int unsigned IN_W = c3rmt_pkg::DefInW,
    parameter int unsigned STRIDE = c3rmt_pkg::DefStride,
    parameter int unsigned HIDDEN_COUNT = c3rmt_pkg::DefHiddenCount
) (
    input wire i_clk,
    input wire i_rst_n,
    c3rmt_in_if.sink i_in,
    c3rmt_out_if.source o_out,
    c3rmt_cfg_if.sink i_cfg
);
    import c3rmt_pkg::*;

    localparam int unsigned WCOUNT = NUM_FILTERS * Taps;
    localparam int unsigned POSITIONS = OUT_H * OUT_W;
    localparam int unsigned WW = $clog2(WCOUNT + 1);
    localparam int unsigned PW = $clog2(POSITIONS + 1);
    localparam int unsigned HA = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int unsigned WA = (WCOUNT > 1) ? $clog2(WCOUNT) : 1;
    localparam int unsigned RW = (OUT_H > 1) ? $clog2(OUT_H) : 1;
    localparam int unsigned CW = (OUT_W > 1) ? $clog2(OUT_W) : 1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_F_ADDR = 5'd1;
    localparam logic [4:0] S_F_MUL = 5'd2;
    localparam logic [4:0] S_F_ACC = 5'd3;
    localparam logic [4:0] S_F_OUT = 5'd4;
    localparam logic [4:0] S_B_ADDR = 5'd5;
    localparam logic [4:0] S_B_MUL = 5'd6;
    localparam logic [4:0] S_B_ACC = 5'd7;
    localparam logic [4:0] S_B_MOM = 5'd8;
    localparam logic [4:0] S_B_SCL = 5'd9;
    localparam logic [4:0] S_B_UPD = 5'd10;
    localparam logic [4:0] S_W_RD = 5'd11;
    localparam logic [4:0] S_W_UPD = 5'd12;
    localparam logic [4:0] S_R_RD = 5'd13;
    localparam logic [4:0] S_R_OUT = 5'd14;
    localparam logic [4:0] S_SCALE = 5'd15;
    localparam logic [4:0] S_B_SCH = 5'd16;

    logic signed [15:0] r_wmem [WCOUNT];
    logic signed [31:0] r_cmem [WCOUNT];
    logic [WCOUNT-1:0] r_cvalid;
    logic signed [15:0] r_imem [ImageDepth];
    logic signed [15:0] r_amem [HIDDEN_COUNT];
    logic signed [15:0] r_emem [HIDDEN_COUNT];

    logic [4:0] r_state;
    logic [15:0] r_rate, r_mom;
    logic [PW-1:0] r_pos;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [3:0] r_tap;
    logic [1:0] r_trow, r_tcol;
    logic [2:0] r_filt;
    logic [WW-1:0] r_k;
    logic signed [47:0] r_acc;
    logic signed [15:0] r_wd, r_pd, r_ad, r_ed;
    logic r_pok;
    logic signed [31:0] r_cd;
    logic signed [31:0] r_mul;
    logic [16:0] r_scale;
    logic signed [63:0] r_tmp;
    logic r_ovalid;
    t_out_item r_opay;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [31:0] pix_addr;
    assign pix_addr = (32'(r_row) * STRIDE + 32'(r_trow)) * IN_W + 32'(r_col) * STRIDE
        + 32'(r_tcol);
    logic [31:0] act_addr;
    assign act_addr = 32'(r_pos) * NUM_FILTERS + 32'(r_filt);
    logic [31:0] wk;
    assign wk = 32'(r_filt) * Taps + 32'(r_tap);
    logic [WA-1:0] w_raddr;
    assign w_raddr = (r_state == S_W_RD || r_state == S_R_RD) ? WA'(r_k) : WA'(wk);

    logic [RW-1:0] pos_row;
    logic [CW-1:0] pos_col;
    always_comb begin
        pos_row = '0;
        pos_col = CW'(i_in.payload.index);
        for (int j = 1; j < OUT_H; j++) begin
            if (32'(i_in.payload.index) >= j * OUT_W) begin
                pos_row = RW'(j);
                pos_col = CW'(32'(i_in.payload.index) - j * OUT_W);
            end
        end
    end

    logic [2:0] rd_filt;
    always_comb begin
        rd_filt = '0;
        for (int j = 1; j < NUM_FILTERS; j++) begin
            if (32'(r_k) >= j * Taps) rd_filt = 3'(j);
        end
    end

    function automatic logic signed [63:0] rshift(input logic signed [63:0] x,
                                                  input int s);
        logic signed [63:0] y;
        y = x + (64'sd1 <<< (s - 1));
        return y >>> s;
    endfunction

    logic signed [63:0] rnd;
    logic signed [63:0] sum_ch;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_F_MUL: begin
                mul_a = 33'(r_wd);
                mul_b = 33'(r_pd);
            end
            S_B_MUL: begin
                mul_a = 33'(r_pd);
                mul_b = 33'(r_ed);
            end
            S_B_MOM: begin
                mul_a = 33'(r_cd);
                mul_b = $signed({17'd0, r_mom});
            end
            S_SCALE: begin
                mul_a = $signed(33'(17'd65536 - {1'b0, r_mom}));
                mul_b = $signed({17'd0, r_rate});
            end
            S_B_SCL: begin
                mul_a = $signed({17'd0, r_acc[15:0]});
                mul_b = $signed({16'd0, r_scale});
            end
            S_B_SCH: begin
                mul_a = 33'($signed(r_acc[47:16]));
                mul_b = $signed({16'd0, r_scale});
            end
            default: ;
        endcase
        rnd = rshift(64'(r_acc), 12);
        sum_ch = 64'(r_cd) + rshift(r_tmp, 16);
    end

    logic in_fire;
    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.payload = r_opay;

    logic signed [63:0] wq;
    assign wq = 64'(r_wd) * 4096 - 64'(r_cd);
    logic signed [63:0] wq_r;
    assign wq_r = rshift(wq, 12);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (i_in.payload.mode == MODE_LOAD_W && 32'(i_in.payload.index) < WCOUNT)
                r_wmem[WA'(i_in.payload.index)] <= i_in.payload.value;
            if (i_in.payload.mode == MODE_LOAD_P && 32'(i_in.payload.index) < ImageDepth)
                r_imem[i_in.payload.index[7:0]] <= i_in.payload.value;
            if (i_in.payload.mode == MODE_LOAD_E && 32'(i_in.payload.index) < HIDDEN_COUNT)
                r_emem[HA'(i_in.payload.index)] <= i_in.payload.value;
        end
        r_wd <= r_wmem[w_raddr];
        r_pok <= pix_addr < ImageDepth;
        r_pd <= r_imem[pix_addr[7:0]];
        r_ad <= r_amem[HA'(act_addr)];
        r_ed <= r_emem[HA'(act_addr)];
        if (r_state == S_F_OUT && !r_ovalid && act_addr < HIDDEN_COUNT)
            r_amem[HA'(act_addr)] <= (r_acc <= 0) ? 16'sd0
                : ((rnd > 32767) ? 16'sd32767 : rnd[15:0]);
        if (r_state == S_B_UPD)
            r_cmem[WA'(r_k)] <= (sum_ch > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF
                : (sum_ch < -64'sh80000000) ? 32'sh80000000 : sum_ch[31:0];
        if (r_state == S_W_UPD)
            r_wmem[WA'(r_k)] <= (wq_r > 32767) ? 16'sh7FFF
                : (wq_r < -32768) ? 16'sh8000 : wq_r[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate <= 16'd655;
            r_mom <= 16'd39322;
            r_cvalid <= '0;
            r_ovalid <= 1'b0;
            r_pos <= '0;
            r_row <= '0;
            r_col <= '0;
            r_tap <= '0;
            r_trow <= '0;
            r_tcol <= '0;
            r_filt <= '0;
            r_k <= '0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.payload.index == REG_RATE) r_rate <= i_cfg.payload.data;
                else r_mom <= i_cfg.payload.data;
            end
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_tap <= '0;
                        r_trow <= '0;
                        r_tcol <= '0;
                        r_filt <= '0;
                        r_acc <= '0;
                        case (i_in.payload.mode)
                            MODE_FWD: begin
                                if (32'(i_in.payload.index) < POSITIONS) begin
                                    r_pos <= PW'(i_in.payload.index);
                                    r_row <= pos_row;
                                    r_col <= pos_col;
                                    r_state <= S_F_ADDR;
                                end
                            end
                            MODE_BWD: begin
                                r_state <= S_SCALE;
                                r_pos <= '0;
                                r_row <= '0;
                                r_col <= '0;
                                r_k <= '0;
                            end
                            MODE_READ_W: begin
                                if (32'(i_in.payload.index) < WCOUNT) begin
                                    r_k <= WW'(i_in.payload.index);
                                    r_state <= S_R_RD;
                                end
                            end
                            MODE_CLEAR: r_cvalid <= '0;
                            default: ;
                        endcase
                    end
                end
                S_SCALE: begin
                    r_scale <= 17'((mul_p + 66'sd32768) >>> 16);
                    r_state <= S_B_ADDR;
                end
                S_F_ADDR: r_state <= S_F_MUL;
                S_F_MUL: begin
                    r_mul <= r_pok ? mul_p[31:0] : 32'sd0;
                    r_state <= S_F_ACC;
                end
                S_F_ACC: begin
                    r_acc <= r_acc + 48'(r_mul);
                    if (r_tap == 4'(Taps - 1)) begin
                        r_state <= S_F_OUT;
                    end else begin
                        r_tap <= r_tap + 4'd1;
                        if (r_tcol == 2'(Ksize - 1)) begin
                            r_tcol <= '0;
                            r_trow <= r_trow + 2'd1;
                        end else r_tcol <= r_tcol + 2'd1;
                        r_state <= S_F_ADDR;
                    end
                end
                S_F_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_opay.result_value <= (r_acc <= 0) ? 16'sd0
                            : ((rnd > 32767) ? 16'sd32767 : rnd[15:0]);
                        r_opay.filter_number <= r_filt;
                        r_opay.last <= (32'(r_filt) == NUM_FILTERS - 1);
                        r_acc <= '0;
                        r_tap <= '0;
                        r_trow <= '0;
                        r_tcol <= '0;
                        if (32'(r_filt) == NUM_FILTERS - 1) r_state <= S_IDLE;
                        else begin
                            r_filt <= r_filt + 3'd1;
                            r_state <= S_F_ADDR;
                        end
                    end
                end
                S_B_ADDR: r_state <= S_B_MUL;
                S_B_MUL: begin
                    r_mul <= (r_pok && act_addr < HIDDEN_COUNT && r_ad > 0)
                        ? mul_p[31:0] : 32'sd0;
                    r_state <= S_B_ACC;
                end
                S_B_ACC: begin
                    r_acc <= r_acc + 48'(r_mul);
                    if (32'(r_pos) == POSITIONS - 1) begin
                        r_pos <= '0;
                        r_row <= '0;
                        r_col <= '0;
                        r_cd <= r_cvalid[WA'(r_k)] ? r_cmem[WA'(r_k)] : 32'sd0;
                        r_state <= S_B_MOM;
                    end else begin
                        r_pos <= r_pos + PW'(1);
                        if (r_col == CW'(OUT_W - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + RW'(1);
                        end else r_col <= r_col + CW'(1);
                        r_state <= S_B_ADDR;
                    end
                end
                S_B_MOM: begin
                    r_cd <= 32'(rshift(64'(mul_p), 16));
                    r_state <= S_B_SCL;
                end
                S_B_SCL: begin
                    r_tmp <= 64'(mul_p);
                    r_state <= S_B_SCH;
                end
                S_B_SCH: begin
                    r_tmp <= r_tmp + (64'(mul_p) <<< 16);
                    r_state <= S_B_UPD;
                end
                S_B_UPD: begin
                    r_cvalid[WA'(r_k)] <= 1'b1;
                    r_acc <= '0;
                    if (32'(r_k) == WCOUNT - 1) begin
                        r_k <= '0;
                        r_state <= S_W_RD;
                    end else begin
                        r_k <= r_k + WW'(1);
                        if (r_tap == 4'(Taps - 1)) begin
                            r_tap <= '0;
                            r_trow <= '0;
                            r_tcol <= '0;
                            r_filt <= r_filt + 3'd1;
                        end else begin
                            r_tap <= r_tap + 4'd1;
                            if (r_tcol == 2'(Ksize - 1)) begin
                                r_tcol <= '0;
                                r_trow <= r_trow + 2'd1;
                            end else r_tcol <= r_tcol + 2'd1;
                        end
                        r_state <= S_B_ADDR;
                    end
                end
                S_W_RD: begin
                    r_cd <= r_cmem[WA'(r_k)];
                    r_state <= S_W_UPD;
                end
                S_W_UPD: begin
                    if (32'(r_k) == WCOUNT - 1) r_state <= S_IDLE;
                    else begin
                        r_k <= r_k + WW'(1);
                        r_state <= S_W_RD;
                    end
                end
                S_R_RD: r_state <= S_R_OUT;
                S_R_OUT: begin
                    r_opay.result_value <= r_wd;
                    r_opay.filter_number <= rd_filt;
                    r_opay.last <= 1'b1;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/conv_layer_watch.sv -----
`timescale 1ns / 1ps
module conv_layer_watch (
    input  logic   i_clk,
    input  logic   i_rst_n,
    c3rmt_in_if    in_ch,
    c3rmt_out_if   out_ch,
    c3rmt_cfg_if   cfg_ch,
    output int     o_mismatches,
    output int     o_outstanding
);
    import c3rmt_pkg::*;

    localparam int NF = DefNumFilters;
    localparam int WCOUNT = DefNumFilters * Taps;
    localparam int POSITIONS = DefOutH * DefOutW;

    logic signed [15:0] weights [WCOUNT];
    logic signed [31:0] changes [WCOUNT];
    logic signed [15:0] pixels [ImageDepth];
    logic signed [15:0] acts [DefHiddenCount];
    logic signed [15:0] errs [DefHiddenCount];
    logic [15:0] rate;
    logic [15:0] momentum;
    t_out_item pending_results [$];

    function automatic longint round_down(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip16(longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint pixel_of(int pos, int tap);
        int h;
        int w;
        int a;
        h = pos / DefOutW;
        w = pos % DefOutW;
        a = (h * DefStride + tap / Ksize) * DefInW + w * DefStride + tap % Ksize;
        if (a < ImageDepth) return longint'(pixels[a]);
        return 0;
    endfunction

    task automatic forward_position(int pos);
        longint sum;
        longint act;
        int a;
        t_out_item r;
        for (int f = 0; f < NF; f++) begin
            sum = 0;
            for (int t = 0; t < Taps; t++)
                sum += longint'(weights[f * Taps + t]) * pixel_of(pos, t);
            act = (sum <= 0) ? 0 : clip16(round_down(sum, 12));
            a = pos * NF + f;
            if (a < DefHiddenCount) acts[a] = act[15:0];
            r.result_value = act[15:0];
            r.filter_number = f[2:0];
            r.last = (f == NF - 1);
            pending_results.push_back(r);
        end
    endtask

    task automatic update_weights();
        longint scale;
        longint sum;
        longint ch;
        longint wq;
        int k;
        int a;
        scale = ((65536 - longint'(momentum)) * longint'(rate) + 32768) >>> 16;
        for (int f = 0; f < NF; f++) begin
            for (int t = 0; t < Taps; t++) begin
                k = f * Taps + t;
                sum = 0;
                for (int p = 0; p < POSITIONS; p++) begin
                    a = p * NF + f;
                    if (a < DefHiddenCount && acts[a] > 0)
                        sum += pixel_of(p, t) * longint'(errs[a]);
                end
                ch = round_down(longint'(changes[k]) * longint'(momentum), 16);
                ch += round_down(sum * scale, 16);
                ch = clip32(ch);
                changes[k] = ch[31:0];
            end
        end
        for (int i = 0; i < WCOUNT; i++) begin
            wq = longint'(weights[i]) * 4096 - longint'(changes[i]);
            wq = clip16(round_down(wq, 12));
            weights[i] = wq[15:0];
        end
    endtask

    task automatic apply_item(t_in_item it);
        int idx;
        t_out_item r;
        idx = it.index;
        case (it.mode)
            MODE_LOAD_W: if (idx < WCOUNT) weights[idx] = it.value;
            MODE_LOAD_P: if (idx < ImageDepth) pixels[idx] = it.value;
            MODE_LOAD_E: if (idx < DefHiddenCount) errs[idx] = it.value;
            MODE_FWD: if (idx < POSITIONS) forward_position(idx);
            MODE_BWD: update_weights();
            MODE_READ_W: begin
                if (idx < WCOUNT) begin
                    r.result_value = weights[idx];
                    r.filter_number = 3'(idx / Taps);
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
            end
            MODE_CLEAR: foreach (changes[i]) changes[i] = '0;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            o_mismatches = 0;
            pending_results.delete();
            rate = 16'd655;
            momentum = 16'd39322;
            foreach (changes[i]) changes[i] = '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.payload.index == REG_RATE) rate = cfg_ch.payload.data;
                else momentum = cfg_ch.payload.data;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (pending_results.size() == 0) begin
                    $error("result_value: no item expected, got %0d", got.result_value);
                    o_mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, got.result_value);
                        o_mismatches++;
                    end
                    if (got.filter_number !== want.filter_number) begin
                        $error("filter_number: expected %0d, got %0d",
                               want.filter_number, got.filter_number);
                        o_mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        o_mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) apply_item(in_ch.payload);
        end
        o_outstanding = pending_results.size();
    end

    initial begin
        o_mismatches = 0;
        o_outstanding = 0;
    end
endmodule

// ----- tb/sv/tb_conv3x3_relu_momentum_trainer.sv -----
`timescale 1ns / 1ps
module tb_conv3x3_relu_momentum_trainer;
    import c3rmt_pkg::*;

    localparam int WCOUNT = DefNumFilters * Taps;
    localparam int POSITIONS = DefOutH * DefOutW;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int mismatches;
    int outstanding;
    int burst_left = 0;
    bit hold_req = 0;

    c3rmt_in_if in_ch ();
    c3rmt_out_if out_ch ();
    c3rmt_cfg_if cfg_ch ();

    conv3x3_relu_momentum_trainer DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    conv_layer_watch watch (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_ch(cfg_ch),
        .o_mismatches(mismatches),
        .o_outstanding(outstanding)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #60_000_000;
        $display("tb_conv3x3_relu_momentum_trainer: done, errors");
        $finish;
    end

    task automatic send_item(logic [2:0] mode, int idx, logic [15:0] val);
        t_in_item it;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        it.mode = mode;
        it.index = idx[10:0];
        it.value = val;
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0 || !in_ch.ready) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        t_cfg_item c;
        drain();
        c.index = idx;
        c.data = data;
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= c;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_value();
        if ($urandom_range(0, 1)) return 16'($urandom);
        return 16'($urandom_range(0, 4095) - 2048);
    endfunction

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_item(MODE_FWD, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                            : $urandom_range(0, POSITIONS - 1),
                      16'($urandom));
        else if (pick < 55)
            send_item(MODE_READ_W, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                               : $urandom_range(0, WCOUNT - 1),
                      16'($urandom));
        else if (pick < 70)
            send_item(MODE_LOAD_W, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                               : $urandom_range(0, WCOUNT - 1),
                      rand_value());
        else if (pick < 82)
            send_item(MODE_LOAD_P, $urandom_range(0, 2047) & (($urandom_range(0, 5) == 0)
                                                              ? 2047 : 255), rand_value());
        else if (pick < 92)
            send_item(MODE_LOAD_E, $urandom_range(0, 2047), rand_value());
        else if (pick < 96)
            send_item(MODE_CLEAR, $urandom_range(0, 2047), 16'($urandom));
        else
            send_item(3'd7, $urandom_range(0, 2047), 16'($urandom));
    endtask

    initial begin
        int stall_mode;
        out_ch.ready <= 1'b0;
        stall_mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
                case (stall_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    initial begin
        logic [15:0] rates [5];
        logic [15:0] moms [5];
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.payload <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_RATE, 16'd4000);
        write_reg(REG_MOMENTUM, 16'd30000);
        for (int i = 0; i < WCOUNT; i++)
            send_item(MODE_LOAD_W, i, 16'($urandom_range(0, 2047) - 1024));
        for (int i = 0; i < ImageDepth; i++)
            send_item(MODE_LOAD_P, i, 16'($urandom_range(0, 8191) - 2048));
        for (int i = 0; i < DefHiddenCount; i++)
            send_item(MODE_LOAD_E, i, rand_value());
        for (int p = 0; p < POSITIONS; p++)
            send_item(MODE_FWD, p, 16'($urandom));

        send_item(MODE_LOAD_W, 0, 16'h7fff);
        send_item(MODE_LOAD_W, WCOUNT - 1, 16'h8000);
        send_item(MODE_LOAD_W, WCOUNT, 16'h1234);
        send_item(MODE_LOAD_P, 0, 16'h7fff);
        send_item(MODE_LOAD_P, ImageDepth - 1, 16'h8000);
        send_item(MODE_LOAD_P, 2047, 16'h5555);
        send_item(MODE_LOAD_E, DefHiddenCount - 1, 16'h8000);
        send_item(MODE_LOAD_E, 2047, 16'h7fff);
        send_item(MODE_FWD, 0, 16'h0000);
        send_item(MODE_FWD, POSITIONS - 1, 16'hffff);
        send_item(MODE_FWD, POSITIONS, 16'h0000);
        send_item(MODE_FWD, 2047, 16'h0000);
        send_item(MODE_READ_W, 0, 16'h0000);
        send_item(MODE_READ_W, WCOUNT - 1, 16'h0000);
        send_item(MODE_READ_W, WCOUNT, 16'h0000);
        send_item(MODE_READ_W, 2047, 16'hffff);
        send_item(3'd7, 2047, 16'hffff);
        send_item(MODE_BWD, 0, 16'h0000);
        send_item(MODE_READ_W, 9, 16'h0000);
        send_item(MODE_CLEAR, 0, 16'h0000);
        send_item(MODE_BWD, 0, 16'h0000);
        send_item(MODE_READ_W, 10, 16'h0000);

        rates = '{16'd0, 16'd65535, 16'd655, 16'd65535, 16'($urandom)};
        moms = '{16'd0, 16'd65535, 16'd39322, 16'd0, 16'($urandom)};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_RATE, rates[ph]);
            write_reg(REG_MOMENTUM, moms[ph]);
            if (ph == 2) begin
                hold_req = 1;
                for (int i = 0; i < 12; i++)
                    send_item(MODE_FWD, $urandom_range(0, 195), 16'h0000);
            end
            for (int i = 0; i < 80; i++) begin
                if (i == 40) send_item(MODE_BWD, $urandom_range(0, 2047), 16'($urandom));
                random_item();
            end
            send_item(MODE_READ_W, $urandom_range(0, WCOUNT - 1), 16'($urandom));
        end

        drain();
        if (mismatches == 0)
            $display("tb_conv3x3_relu_momentum_trainer: done, clean");
        else
            $display("tb_conv3x3_relu_momentum_trainer: done, errors");
        $finish;
    end
endmodule
